[rtl/core/dht_pkg.sv]
// Package for the double-hashing table: request and result types, status codes,
// default sizes and fixed field widths. No dependencies.
package dht_pkg;

    localparam int KEY_W      = 31;
    localparam int MODE_W     = 1;
    localparam int STATUS_W   = 2;
    localparam int SLOT_W     = 4;
    localparam int ENTRY_W    = KEY_W + 1;   // valid bit on top of the key

    // key is reduced one 4-bit digit per cycle, padded to a whole digit count
    localparam int DIGIT_W    = 4;
    localparam int DIGITS     = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int KEY_PAD_W  = DIGITS * DIGIT_W;
    localparam int DIG_CNT_W  = $clog2(DIGITS);

    localparam int DEF_TABLE_SLOTS = 13;
    localparam int DEF_STEP_PRIME  = 7;

    localparam logic [MODE_W-1:0] MODE_INSERT = 1'b0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_REMOVED   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [KEY_W-1:0]  key;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } res_t;

endpackage

[rtl/core/double_hash_table.sv]
// Open-addressing hash table with double hashing, slots held in one synchronous RAM.
// A request is accepted, hashed digit by digit, probed through up to TABLE_SLOTS slots and
// then placed in the result register. One request at a time; the rate is set by the
// digit-serial mod units and the single RAM read port.
// Reset: control clears at once, then a clearing pass writes every slot empty, during
// which no request is taken.
module double_hash_table
    import dht_pkg::*;
#(
    parameter int TABLE_SLOTS = DEF_TABLE_SLOTS,
    parameter int STEP_PRIME  = DEF_STEP_PRIME
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req_data,
    output logic res_valid,
    input  logic res_stall,
    output res_t res_data
);

    localparam int IDX_W = $clog2(TABLE_SLOTS);
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int PW    = $clog2(STEP_PRIME);
    localparam int SW    = $clog2(STEP_PRIME + 1);
    localparam int HX_W  = IDX_W + DIGIT_W;
    localparam int PX_W  = PW + DIGIT_W;
    localparam int MULTS = (1 << DIGIT_W);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_HASH  = 3'd2;
    localparam logic [2:0] ST_PROBE = 3'd3;
    localparam logic [2:0] ST_POST  = 3'd4;

    logic [2:0]           state_reg,     state_next;
    logic [IDX_W-1:0]     clr_reg,       clr_next;
    logic [DIG_CNT_W-1:0] dig_reg,       dig_next;
    logic [KEY_PAD_W-1:0] shift_reg,     shift_next;
    logic [IDX_W-1:0]     rem_h_reg,     rem_h_next;
    logic [PW-1:0]        rem_p_reg,     rem_p_next;
    logic [MODE_W-1:0]    mode_reg,      mode_next;
    logic [KEY_W-1:0]     key_reg,       key_next;
    logic [IDX_W-1:0]     addr_reg,      addr_next;
    logic [SW-1:0]        step_reg,      step_next;
    logic [CNT_W-1:0]     iss_reg,       iss_next;
    logic [CNT_W-1:0]     chk_reg,       chk_next;
    logic                 pend_reg,      pend_next;
    logic [IDX_W-1:0]     pend_addr_reg, pend_addr_next;
    res_t                 stage_reg,     stage_next;
    logic                 res_valid_reg, res_valid_next;
    res_t                 res_data_reg,  res_data_next;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;

    logic [DIGIT_W-1:0]   digit;
    logic [HX_W-1:0]      ext_h, sub_h;
    logic [PX_W-1:0]      ext_p, sub_p;
    logic [IDX_W-1:0]     rem_h_new;
    logic [PW-1:0]        rem_p_new;
    logic [IDX_W:0]       addr_sum;
    logic [IDX_W-1:0]     addr_adv;
    logic                 ent_valid;
    logic [KEY_W-1:0]     ent_key;
    logic                 res_free;

    dht_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    // digit-serial mod: rem = (rem * 16 + digit) mod M, one constant-multiple pick per cycle
    always_comb
    begin
        digit = shift_reg[KEY_PAD_W-1 -: DIGIT_W];
        ext_h = {rem_h_reg, digit};
        ext_p = {rem_p_reg, digit};
        sub_h = '0;
        sub_p = '0;
        for (int k = 1; k < MULTS; k++)
        begin
            if (ext_h >= HX_W'(k * TABLE_SLOTS))
            begin
                sub_h = HX_W'(k * TABLE_SLOTS);
            end
            if (ext_p >= PX_W'(k * STEP_PRIME))
            begin
                sub_p = PX_W'(k * STEP_PRIME);
            end
        end
        rem_h_new = IDX_W'(ext_h - sub_h);
        rem_p_new = PW'(ext_p - sub_p);
    end

    always_comb
    begin
        addr_sum = {1'b0, addr_reg} + (IDX_W + 1)'(step_reg);
        if (addr_sum >= (IDX_W + 1)'(TABLE_SLOTS))
        begin
            addr_sum = addr_sum - (IDX_W + 1)'(TABLE_SLOTS);
        end
        addr_adv = addr_sum[IDX_W-1:0];
    end

    assign ent_valid = ram_rdata[ENTRY_W-1];
    assign ent_key   = ram_rdata[KEY_W-1:0];
    assign res_free  = !res_valid_reg || !res_stall;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        dig_next       = dig_reg;
        shift_next     = shift_reg;
        rem_h_next     = rem_h_reg;
        rem_p_next     = rem_p_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        addr_next      = addr_reg;
        step_next      = step_reg;
        iss_next       = iss_reg;
        chk_next       = chk_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        stage_next     = stage_reg;
        res_valid_next = res_valid_reg;
        res_data_next  = res_data_reg;
        ram_we         = 1'b0;
        ram_waddr      = pend_addr_reg;
        ram_wdata      = '0;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req_data.mode;
                    key_next   = req_data.key;
                    shift_next = KEY_PAD_W'(req_data.key);
                    rem_h_next = '0;
                    rem_p_next = '0;
                    dig_next   = '0;
                    state_next = ST_HASH;
                end
            end
            ST_HASH:
            begin
                rem_h_next = rem_h_new;
                rem_p_next = rem_p_new;
                shift_next = shift_reg << DIGIT_W;
                dig_next   = dig_reg + 1'b1;
                if (dig_reg == DIG_CNT_W'(DIGITS - 1))
                begin
                    addr_next  = rem_h_new;
                    step_next  = SW'(STEP_PRIME) - SW'(rem_p_new);
                    iss_next   = '0;
                    chk_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // read one slot a cycle; the previous read is judged alongside
                pend_next = 1'b0;
                if (iss_reg < CNT_W'(TABLE_SLOTS))
                begin
                    iss_next       = iss_reg + 1'b1;
                    addr_next      = addr_adv;
                    pend_next      = 1'b1;
                    pend_addr_next = addr_reg;
                end
                if (pend_reg)
                begin
                    chk_next = chk_reg + 1'b1;
                    if (mode_reg == MODE_INSERT)
                    begin
                        if (!ent_valid)
                        begin
                            ram_we            = 1'b1;
                            ram_wdata         = {1'b1, key_reg};
                            stage_next.status = STATUS_INSERTED;
                            stage_next.slot   = SLOT_W'(pend_addr_reg);
                            state_next        = ST_POST;
                        end
                        else if (chk_reg == CNT_W'(TABLE_SLOTS - 1))
                        begin
                            stage_next.status = STATUS_FULL;
                            stage_next.slot   = '0;
                            state_next        = ST_POST;
                        end
                    end
                    else
                    begin
                        if (!ent_valid)
                        begin
                            stage_next.status = STATUS_NOT_FOUND;
                            stage_next.slot   = '0;
                            state_next        = ST_POST;
                        end
                        else if (ent_key == key_reg)
                        begin
                            ram_we            = 1'b1;
                            ram_wdata         = '0;
                            stage_next.status = STATUS_REMOVED;
                            stage_next.slot   = SLOT_W'(pend_addr_reg);
                            state_next        = ST_POST;
                        end
                        else if (chk_reg == CNT_W'(TABLE_SLOTS - 1))
                        begin
                            stage_next.status = STATUS_NOT_FOUND;
                            stage_next.slot   = '0;
                            state_next        = ST_POST;
                        end
                    end
                end
            end
            ST_POST:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = stage_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            dig_reg       <= '0;
            iss_reg       <= '0;
            chk_reg       <= '0;
            pend_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            dig_reg       <= dig_next;
            iss_reg       <= iss_next;
            chk_reg       <= chk_next;
            pend_reg      <= pend_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg     <= shift_next;
        rem_h_reg     <= rem_h_next;
        rem_p_reg     <= rem_p_next;
        mode_reg      <= mode_next;
        key_reg       <= key_next;
        addr_reg      <= addr_next;
        step_reg      <= step_next;
        pend_addr_reg <= pend_addr_next;
        stage_reg     <= stage_next;
        res_data_reg  <= res_data_next;
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    a_iss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        iss_reg <= CNT_W'(TABLE_SLOTS))
        else $error("probe issue count past table size");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (addr_reg < IDX_W'(TABLE_SLOTS) && step_reg != '0
            && step_reg <= SW'(STEP_PRIME)))
        else $error("probe address or step out of range");

    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == ST_POST))
        else $error("result raised outside post state");

    a_write_judged: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && state_reg == ST_PROBE) |=> (state_reg == ST_POST))
        else $error("slot write without finishing request");

endmodule

[rtl/core/dht_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
module dht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[verif/dht_check.sv]
`timescale 1ns / 1ps
// Channel watcher for double_hash_table: keeps its own copy of the slot table, predicts
// each result from the accepted requests and compares in order. Depends on dht_pkg.
module dht_check
    import dht_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_stall,
    input  req_t req_data,
    input  logic res_valid,
    input  logic res_stall,
    input  res_t res_data,
    output int   mismatches,
    output int   awaiting
);

    localparam int SLOTS = DEF_TABLE_SLOTS;
    localparam int PRIME = DEF_STEP_PRIME;

    logic             slot_used [SLOTS];
    logic [KEY_W-1:0] slot_key  [SLOTS];
    res_t             due_results [$];

    // walks the probe sequence on the local table copy and updates it
    function automatic res_t hash_apply(req_t r);
        int unsigned k;
        int unsigned idx;
        int unsigned step;
        logic        done;
        res_t        res;
        k    = 32'(r.key);
        idx  = k % SLOTS;
        step = PRIME - (k % PRIME);
        done = 1'b0;
        res.slot = '0;
        if (r.mode == MODE_INSERT)
        begin
            res.status = STATUS_FULL;
            for (int n = 0; n < SLOTS && !done; n++)
            begin
                if (!slot_used[idx])
                begin
                    slot_used[idx] = 1'b1;
                    slot_key[idx]  = r.key;
                    res.status     = STATUS_INSERTED;
                    res.slot       = SLOT_W'(idx);
                    done           = 1'b1;
                end
                else
                    idx = (idx + step) % SLOTS;
            end
        end
        else
        begin
            res.status = STATUS_NOT_FOUND;
            for (int n = 0; n < SLOTS && !done; n++)
            begin
                if (!slot_used[idx])
                    done = 1'b1;        // empty slot ends the search
                else if (slot_key[idx] == r.key)
                begin
                    slot_used[idx] = 1'b0;
                    slot_key[idx]  = '0;
                    res.status     = STATUS_REMOVED;
                    res.slot       = SLOT_W'(idx);
                    done           = 1'b1;
                end
                else
                    idx = (idx + step) % SLOTS;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        res_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                slot_used[i] = 1'b0;
                slot_key[i]  = '0;
            end
            due_results.delete();
            awaiting   = 0;
            mismatches = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (due_results.size() == 0)
                begin
                    $display("%0t: result with nothing pending: status %0d slot %0d",
                             $time, res_data.status, res_data.slot);
                    mismatches++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (res_data.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.status, res_data.status);
                        mismatches++;
                    end
                    if (res_data.slot !== want.slot)
                    begin
                        $display("%0t: slot mismatch: expected %0d, got %0d",
                                 $time, want.slot, res_data.slot);
                        mismatches++;
                    end
                end
            end
            if (req_valid && !req_stall)
                due_results.push_back(hash_apply(req_data));
            awaiting = due_results.size();
        end
    end

endmodule

[verif/double_hash_table_tb.sv]
`timescale 1ns / 1ps
// Top of the double_hash_table testbench: clock, reset, request stimulus and result stall.
// Depends on dht_pkg, double_hash_table and dht_check.
module double_hash_table_tb
    import dht_pkg::*;
();

    localparam int RANDOM_ITEMS = 552;
    localparam int PHASES       = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req_data  = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res_data;

    int mismatches;
    int awaiting;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asks      = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycles         = 0;

    logic [KEY_W-1:0] key_pool [$];

    always #5 clk = ~clk;

    double_hash_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    dht_check watch (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_data   (req_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .mismatches (mismatches),
        .awaiting   (awaiting)
    );

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("double_hash_table verification failed");
            $finish;
        end
    end

    // result side: random stall, or a long hold-off when one is asked for
    always @(posedge clk)
    begin
        if (hold_asks != hold_served)
        begin
            hold_served = hold_asks;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            res_stall <= 1'b1;
        end
        else
            res_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    task automatic send_req(input logic [MODE_W-1:0] op, input logic [KEY_W-1:0] k);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= '{mode: op, key: k};
        do @(posedge clk); while (req_stall);
    endtask

    // removes mostly target keys that were inserted; small keys force collisions
    task automatic random_req(input int insert_pct);
        logic [MODE_W-1:0] op;
        logic [KEY_W-1:0]  k;
        int                pick;
        int                pool_pct;
        int unsigned       choice;
        op       = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_REMOVE;
        pool_pct = (op == MODE_REMOVE) ? 75 : 30;
        choice   = $urandom_range(99);
        if (choice < pool_pct && key_pool.size() > 0)
        begin
            pick = $urandom_range(key_pool.size() - 1);
            k    = key_pool[pick];
            if (op == MODE_REMOVE)
                key_pool.delete(pick);
        end
        else if (choice < 80)
            k = KEY_W'($urandom_range(40));
        else
            k = KEY_W'($urandom);
        if (op == MODE_INSERT && key_pool.size() < 32)
            key_pool.push_back(k);
        send_req(op, k);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // empty table, then fill to the last slot with collisions and a duplicate
        send_req(MODE_REMOVE, 31'd5);
        send_req(MODE_INSERT, 31'd0);
        send_req(MODE_INSERT, 31'h7FFF_FFFF);
        send_req(MODE_INSERT, 31'd13);
        send_req(MODE_INSERT, 31'd0);
        send_req(MODE_INSERT, 31'd26);
        send_req(MODE_INSERT, 31'd1);
        send_req(MODE_INSERT, 31'd2);
        send_req(MODE_INSERT, 31'd100);
        send_req(MODE_INSERT, 31'h5555_5555);
        send_req(MODE_INSERT, 31'h2AAA_AAAA);
        send_req(MODE_INSERT, 31'd7);
        send_req(MODE_INSERT, 31'd14);
        send_req(MODE_INSERT, 31'd12);
        // full table: insert fails, absent key runs the whole sequence
        send_req(MODE_INSERT, 31'd5);
        send_req(MODE_REMOVE, 31'd999);
        send_req(MODE_REMOVE, 31'd0);
        send_req(MODE_REMOVE, 31'd0);
        send_req(MODE_REMOVE, 31'd0);
        send_req(MODE_REMOVE, 31'h7FFF_FFFF);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 65; recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;  recv_stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct = 18; recv_stall_pct = 18;
                end
            endcase
            for (int i = 0; i < RANDOM_ITEMS / PHASES; i++)
            begin
                if (ph == 0 && i == 40)
                    hold_asks++;
                // alternate filling and draining stretches
                random_req(((i / 40) % 2 == 0) ? 70 : 35);
            end
        end
        req_valid <= 1'b0;

        do @(posedge clk); while (awaiting != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && awaiting == 0)
            $display("double_hash_table verification clean");
        else
            $display("double_hash_table verification failed");
        $finish;
    end

endmodule
